FILE: hdl/addressable_led_frame_serializer_defines.svh
// Assertion macros for the LED frame serializer.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ADDRESSABLE_LED_FRAME_SERIALIZER_DEFINES_SVH
`define ADDRESSABLE_LED_FRAME_SERIALIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent
`define ALFS_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("alfs assertion failed");
// Consequent must hold in the cycle after the antecedent
`define ALFS_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("alfs assertion failed");
`else
`define ALFS_ASSERT_SAME(lbl, ant, cons)
`define ALFS_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

FILE: hdl/alfs_pkg.sv
`timescale 1ns / 1ps

package alfs_pkg;

  // Opcodes carried on in_tuser
  localparam logic [1:0] FUNC_SET_PIXEL   = 2'd0;
  localparam logic [1:0] FUNC_FILL        = 2'd1;
  localparam logic [1:0] FUNC_FILL_SCALED = 2'd2;
  localparam logic [1:0] FUNC_PULL        = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER   = 1'd1;

  // Register reset values
  localparam logic [10:0] LED_COUNT_RST = 11'd1;
  localparam logic [7:0]  TRAILER_RST   = 8'd120;

  // Full-scale brightness ratio
  localparam logic [8:0] RATIO_FULL = 9'd256;

  // Byte slot within one LED: 12 slots, 4 per color channel
  localparam logic [3:0] SLOT_LAST = 4'd11;

  // Payload widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // Controller -> datapath commands
  typedef struct packed {
    logic set_px;      // write one pixel, respond with status
    logic fill_go;     // latch fill color and length
    logic fill_scale;  // fill color is scaled by ratio
    logic fill_wr;     // write one store entry of the sweep
    logic fill_zero;   // sweep writes zeros (reset clear)
    logic rsp_fill;    // respond with an all-zero result
    logic pull_go;     // settle position, issue store read
    logic pull_out;    // encode byte, respond, advance position
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic fill_done;   // sweep is at its last entry
  } sts_t;

  // Two data bits to one SPI byte
  function automatic logic [7:0] pair_code(input logic [1:0] pair);
    logic [7:0] code;
    unique case (pair)
      2'b00: code = 8'h88;
      2'b01: code = 8'h8E;
      2'b10: code = 8'hE8;
      2'b11: code = 8'hEE;
      default: code = 8'h88;
    endcase
    return code;
  endfunction

endpackage

FILE: hdl/alfs_ctrl.sv
`timescale 1ns / 1ps

module alfs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [1:0]      in_func,
  output logic            out_tvalid,
  input  logic            out_tready,
  output alfs_pkg::cmd_t  cmd,
  input  alfs_pkg::sts_t  sts
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_FILL  = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take;
  logic       rsp_load;

  // Accept only when idle and the result slot is free or draining
  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign take       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.fill_wr   = 1'b1;
        cmd.fill_zero = 1'b1;
        if (sts.fill_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          unique case (in_func)
            alfs_pkg::FUNC_SET_PIXEL: cmd.set_px = 1'b1;
            alfs_pkg::FUNC_FILL: begin
              cmd.fill_go = 1'b1;
              state_nxt   = S_FILL;
            end
            alfs_pkg::FUNC_FILL_SCALED: begin
              cmd.fill_go    = 1'b1;
              cmd.fill_scale = 1'b1;
              state_nxt      = S_FILL;
            end
            alfs_pkg::FUNC_PULL: begin
              cmd.pull_go = 1'b1;
              state_nxt   = S_READ;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_done) begin
          cmd.rsp_fill = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_READ: begin
        cmd.pull_out = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  assign rsp_load = cmd.set_px || cmd.rsp_fill || cmd.pull_out;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/alfs_datapath.sv
`timescale 1ns / 1ps

module alfs_datapath #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [alfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [9:0]                      led_index,
  input  logic [7:0]                      red,
  input  logic [7:0]                      green,
  input  logic [7:0]                      blue,
  input  logic [8:0]                      ratio,
  input  alfs_pkg::cmd_t                  cmd,
  output alfs_pkg::sts_t                  sts,
  output logic                            rsp_status,
  output logic                            rsp_byte_valid,
  output logic [7:0]                      rsp_byte,
  output logic                            rsp_last
);

  // Address, LED count and frame position widths
  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int NW = $clog2(MAX_LEDS + 1);
  localparam int PW = $clog2(12 * MAX_LEDS + 256);
  // LED counter covers position / 12 over the whole frame, trailer included
  localparam int LW = PW - 3;

  // Configuration registers
  logic [10:0] led_count_r;
  logic [7:0]  trailer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= alfs_pkg::LED_COUNT_RST;
      trailer_r   <= alfs_pkg::TRAILER_RST;
    end else if (cfg_we) begin
      if (cfg_index == alfs_pkg::REG_LED_COUNT) begin
        led_count_r <= cfg_wdata;
      end else if (cfg_index == alfs_pkg::REG_TRAILER) begin
        trailer_r <= cfg_wdata[7:0];
      end
    end
  end

  // LED count clamped to 1..MAX_LEDS
  logic [NW-1:0] leds;

  always_comb begin
    priority if (led_count_r == 11'd0) begin
      leds = NW'(1);
    end else if (32'(led_count_r) > 32'(MAX_LEDS)) begin
      leds = NW'(MAX_LEDS);
    end else begin
      leds = NW'(led_count_r);
    end
  end

  // Pixel color and scaled color (one 8x9 product per channel)
  logic [8:0]  ratio_c;
  logic [16:0] prod_r, prod_g, prod_b;
  logic [23:0] color_raw, color_scaled;
  logic        px_ok;

  assign ratio_c      = (ratio > alfs_pkg::RATIO_FULL) ? alfs_pkg::RATIO_FULL : ratio;
  assign prod_r       = 17'(red) * 17'(ratio_c);
  assign prod_g       = 17'(green) * 17'(ratio_c);
  assign prod_b       = 17'(blue) * 17'(ratio_c);
  assign color_raw    = {green, red, blue};
  assign color_scaled = {prod_g[15:8], prod_r[15:8], prod_b[15:8]};
  assign px_ok        = 32'(led_index) < 32'(leds);

  // Fill sweep: color, counter and last index
  logic [23:0]   color_r;
  logic [AW-1:0] fill_cnt_r, fill_last_r;

  assign sts.fill_done = (fill_cnt_r == fill_last_r);

  always_ff @(posedge clk) begin
    if (cmd.fill_go) begin
      color_r <= cmd.fill_scale ? color_scaled : color_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      fill_last_r <= AW'(MAX_LEDS - 1);
    end else if (cmd.fill_go) begin
      fill_cnt_r  <= '0;
      fill_last_r <= AW'(leds - NW'(1));
    end else if (cmd.fill_wr) begin
      fill_cnt_r <= sts.fill_done ? '0 : fill_cnt_r + AW'(1);
    end
  end

  // Frame geometry
  logic [PW-1:0] pix_len, frame_len;
  logic [PW-1:0] pos_r;
  logic [LW-1:0] led_r;
  logic [3:0]    slot_r;
  logic          wrap, in_pix, is_last;

  assign pix_len   = (PW'(leds) << 3) + (PW'(leds) << 2);
  assign frame_len = pix_len + PW'(trailer_r);
  assign wrap      = pos_r >= frame_len;
  assign in_pix    = pos_r < pix_len;
  assign is_last   = pos_r == (frame_len - PW'(1));

  // Pixel store: one write port, one registered read port
  logic [23:0]   store [MAX_LEDS];
  logic [23:0]   rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [23:0]   wr_data;
  logic          wr_en;

  assign rd_addr = wrap ? '0 : led_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_cnt_r;
    wr_data = cmd.fill_zero ? 24'd0 : color_r;
    if (cmd.set_px) begin
      wr_en   = px_ok;
      wr_addr = AW'(led_index);
      wr_data = color_raw;
    end else if (cmd.fill_wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pull_go) begin
      rd_data_r <= store[rd_addr];
    end
  end

  // Frame position: restart on shortened frame, advance after each byte.
  // LED and slot keep counting through the trailer so they still match
  // the position if the chain is made longer later.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      led_r  <= '0;
      slot_r <= '0;
    end else if (cmd.pull_go) begin
      if (wrap) begin
        pos_r  <= '0;
        led_r  <= '0;
        slot_r <= '0;
      end
    end else if (cmd.pull_out) begin
      if (is_last) begin
        pos_r  <= '0;
        led_r  <= '0;
        slot_r <= '0;
      end else begin
        pos_r <= pos_r + PW'(1);
        if (slot_r == alfs_pkg::SLOT_LAST) begin
          slot_r <= '0;
          led_r  <= led_r + LW'(1);
        end else begin
          slot_r <= slot_r + 4'd1;
        end
      end
    end
  end

  // Byte encoder: channel from slot[3:2], bit pair from slot[1:0]
  logic [7:0] chan_val;
  logic [1:0] pair;
  logic [7:0] enc_byte;

  always_comb begin
    unique case (slot_r[3:2])
      2'd0:    chan_val = rd_data_r[23:16];
      2'd1:    chan_val = rd_data_r[15:8];
      default: chan_val = rd_data_r[7:0];
    endcase
    unique case (slot_r[1:0])
      2'd0: pair = chan_val[7:6];
      2'd1: pair = chan_val[5:4];
      2'd2: pair = chan_val[3:2];
      2'd3: pair = chan_val[1:0];
      default: pair = chan_val[1:0];
    endcase
    enc_byte = in_pix ? alfs_pkg::pair_code(pair) : 8'd0;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.set_px) begin
      rsp_status     <= !px_ok;
      rsp_byte_valid <= 1'b0;
      rsp_byte       <= 8'd0;
      rsp_last       <= 1'b0;
    end else if (cmd.rsp_fill) begin
      rsp_status     <= 1'b0;
      rsp_byte_valid <= 1'b0;
      rsp_byte       <= 8'd0;
      rsp_last       <= 1'b0;
    end else if (cmd.pull_out) begin
      rsp_status     <= 1'b0;
      rsp_byte_valid <= 1'b1;
      rsp_byte       <= enc_byte;
      rsp_last       <= is_last;
    end
  end

endmodule

FILE: hdl/addressable_led_frame_serializer.sv
// Addressable LED frame serializer.
// Input stream carries commands: in_tuser is the opcode (set pixel, fill,
// scaled fill, pull byte), in_tdata the pixel index, color and ratio.
// Every accepted command returns exactly one result on the output stream;
// out_tuser flags a frame byte, out_tlast marks the last byte of a frame.
// Set pixel: the result is valid in the cycle after accept. Pull: one store
// read, then one encode. Fill: one store entry is written per cycle for the
// N LEDs in use, then the result is valid. A new command is taken once
// the previous one is finished and its result slot is free or draining.
// Reset (synchronous, rst_n low) loads led_count=1, trailer_bytes=120,
// rewinds the frame and then runs a clearing pass that zeroes all MAX_LEDS
// entries of the pixel store; in_tready stays low during the pass.
// A stalled receiver holds the result in the output register and holds
// off new commands; nothing is dropped. The user must write configuration
// (cfg_we/cfg_index/cfg_wdata) only while idle; the block does not check it.
`timescale 1ns / 1ps
`include "addressable_led_frame_serializer_defines.svh"

module addressable_led_frame_serializer #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration
  input  logic                            cfg_we,
  input  logic [alfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Command stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // led_index[9:0], red[17:10], green[25:18], blue[33:26], ratio[42:34], zeros
  input  logic [alfs_pkg::IN_TDATA_W-1:0] in_tdata,
  // func[1:0]
  input  logic [1:0]                      in_tuser,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[0], out_byte[8:1], zeros
  output logic [alfs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // byte_valid[0]
  output logic                            out_tuser,
  // frame_last
  output logic                            out_tlast
);

  alfs_pkg::cmd_t cmd;
  alfs_pkg::sts_t sts;
  logic           rsp_status;
  logic [7:0]     rsp_byte;

  alfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  alfs_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .led_index      (in_tdata[9:0]),
    .red            (in_tdata[17:10]),
    .green          (in_tdata[25:18]),
    .blue           (in_tdata[33:26]),
    .ratio          (in_tdata[42:34]),
    .cmd            (cmd),
    .sts            (sts),
    .rsp_status     (rsp_status),
    .rsp_byte_valid (out_tuser),
    .rsp_byte       (rsp_byte),
    .rsp_last       (out_tlast)
  );

  assign out_tdata = {7'd0, rsp_byte, rsp_status};

  // A stalled result blocks new commands
  `ALFS_ASSERT_SAME(a_stall_blocks_input, out_tvalid && !out_tready, !in_tready)
  // A result is either a status or a frame byte, never both
  `ALFS_ASSERT_SAME(a_status_not_byte, out_tvalid && out_tuser, !out_tdata[0])
  // Frame end only comes with a frame byte
  `ALFS_ASSERT_SAME(a_last_is_byte, out_tvalid && out_tlast, out_tuser)
  // A pull occupies the block for its read cycle
  `ALFS_ASSERT_NEXT(a_pull_busy, in_tvalid && in_tready && in_tuser == alfs_pkg::FUNC_PULL, !in_tready)

endmodule

FILE: tb/sv/addressable_led_frame_serializer_tb.sv
`timescale 1ns / 1ps

module addressable_led_frame_serializer_tb;

  localparam int LED_SLOTS = 1024;
  localparam int BYTES_PER_LED = 12;
  // Pair-of-bits to SPI byte codes
  localparam logic [7:0] NRZ_00 = 8'h88;
  localparam logic [7:0] NRZ_01 = 8'h8E;
  localparam logic [7:0] NRZ_10 = 8'hE8;
  localparam logic [7:0] NRZ_11 = 8'hEE;
  // Idling modes
  localparam int MODE_NONE = 0;
  localparam int MODE_SENDER = 1;
  localparam int MODE_RECEIVER = 2;
  localparam int MODE_BOTH = 3;

  typedef struct packed {
    logic       status;
    logic       byte_valid;
    logic [7:0] code;
    logic       frame_last;
  } led_result_t;

  // Mirror of the LED chain: pixel store, frame position, registers
  class led_chain_mirror;
    logic [23:0] pixels [LED_SLOTS];
    logic [10:0] led_count;
    logic [7:0] trailer;
    int unsigned position;
    led_result_t pending[$];
    int unsigned mismatches;
    int unsigned commands;
    int unsigned pulls;
    int unsigned checked;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      led_count = alfs_pkg::LED_COUNT_RST;
      trailer = alfs_pkg::TRAILER_RST;
      position = 0;
      mismatches = 0;
      commands = 0;
      pulls = 0;
      checked = 0;
    endfunction

    function int unsigned leds_in_use();
      int unsigned n;
      n = led_count;
      if (n < 1) n = 1;
      if (n > LED_SLOTS) n = LED_SLOTS;
      return n;
    endfunction

    function logic [7:0] pair_byte(logic [1:0] pair);
      case (pair)
        2'b00: return NRZ_00;
        2'b01: return NRZ_01;
        2'b10: return NRZ_10;
        default: return NRZ_11;
      endcase
    endfunction

    // Encoded byte at a frame position; trailer bytes are zero
    function logic [7:0] frame_byte_at(int unsigned pos, int unsigned leds);
      int unsigned slot;
      int unsigned chan;
      logic [23:0] word;
      logic [7:0] val;
      if (pos >= leds * BYTES_PER_LED) return 8'h00;
      slot = pos % BYTES_PER_LED;
      chan = slot / 4;
      word = pixels[pos / BYTES_PER_LED];
      val = 8'(word >> (16 - 8 * chan));
      return pair_byte(2'(val >> (6 - 2 * (slot % 4))));
    endfunction

    function void fill_pixels(logic [23:0] word);
      int unsigned n;
      n = leds_in_use();
      for (int unsigned i = 0; i < n; i++) pixels[i] = word;
    endfunction

    // Apply one accepted command and queue its result
    function void note_command(logic [1:0] func, logic [9:0] idx, logic [7:0] r,
                               logic [7:0] g, logic [7:0] b, logic [8:0] ratio);
      led_result_t res;
      int unsigned leds;
      int unsigned rt;
      int unsigned len;
      res = '0;
      leds = leds_in_use();
      commands++;
      case (func)
        alfs_pkg::FUNC_SET_PIXEL: begin
          if (idx >= leds) res.status = 1'b1;
          else pixels[idx] = {g, r, b};
        end
        alfs_pkg::FUNC_FILL: fill_pixels({g, r, b});
        alfs_pkg::FUNC_FILL_SCALED: begin
          rt = (ratio > alfs_pkg::RATIO_FULL) ? alfs_pkg::RATIO_FULL : ratio;
          fill_pixels({8'((g * rt) >> 8), 8'((r * rt) >> 8), 8'((b * rt) >> 8)});
        end
        default: begin
          pulls++;
          len = leds * BYTES_PER_LED + trailer;
          if (position >= len) position = 0;
          res.code = frame_byte_at(position, leds);
          res.byte_valid = 1'b1;
          res.frame_last = (position == len - 1);
          position++;
          if (position >= len) position = 0;
        end
      endcase
      pending.push_back(res);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic status, logic [7:0] code, logic valid, logic last);
      led_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected (byte 0x%02h)", code));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (status !== want.status)
        report($sformatf("result %0d status %b, want %b", checked, status, want.status));
      if (valid !== want.byte_valid)
        report($sformatf("result %0d byte_valid %b, want %b", checked, valid,
                         want.byte_valid));
      if (code !== want.code)
        report($sformatf("result %0d byte 0x%02h, want 0x%02h", checked, code, want.code));
      if (last !== want.frame_last)
        report($sformatf("result %0d frame_last %b, want %b", checked, last,
                         want.frame_last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [alfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [alfs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [alfs_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [alfs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned settings_used = 0;
  led_chain_mirror mirror = new();

  addressable_led_frame_serializer dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      mirror.check_result(out_tdata[0], out_tdata[8:1], out_tuser, out_tlast);
  end

  // Present one command and wait for its transfer
  task automatic send_command(logic [1:0] func, logic [9:0] idx, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b, logic [8:0] ratio);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {5'b0, ratio, b, g, r, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.note_command(func, idx, r, g, b, ratio);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic drain;
    in_tvalid <= 1'b0;
    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers, back to back; only called while idle
  task automatic write_config(logic [10:0] leds, logic [7:0] trail);
    cfg_we <= 1'b1;
    cfg_index <= alfs_pkg::REG_LED_COUNT;
    cfg_wdata <= leds;
    @(posedge clk);
    mirror.led_count = leds;
    cfg_index <= alfs_pkg::REG_TRAILER;
    cfg_wdata <= alfs_pkg::CFG_DATA_W'(trail);
    @(posedge clk);
    mirror.trailer = trail;
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      MODE_SENDER: begin
        sender_idle_pct = 86;
        receiver_stall_pct = 0;
      end
      MODE_RECEIVER: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 86;
      end
      MODE_BOTH: begin
        sender_idle_pct = 35;
        receiver_stall_pct = 35;
      end
      default: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
    endcase
  endtask

  // One register setting followed by random commands
  task automatic run_phase(logic [10:0] leds, logic [7:0] trail, int n_items, int mode);
    int unsigned used;
    int unsigned pick;
    int unsigned fill_pct;
    logic [1:0] func;
    logic [9:0] idx;
    logic [8:0] ratio;
    drain();
    write_config(leds, trail);
    set_idling(mode);
    used = mirror.leds_in_use();
    // fills walk every LED in use, so keep them rare on long chains
    fill_pct = (used > 64) ? 5 : 12;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < fill_pct) func = alfs_pkg::FUNC_FILL;
      else if (pick < 2 * fill_pct) func = alfs_pkg::FUNC_FILL_SCALED;
      else if (pick < 2 * fill_pct + 30) func = alfs_pkg::FUNC_SET_PIXEL;
      else func = alfs_pkg::FUNC_PULL;
      if ($urandom_range(9) < 8) idx = 10'($urandom_range(used - 1));
      else idx = 10'($urandom_range(1023));
      case ($urandom_range(9))
        0: ratio = 9'd0;
        1: ratio = alfs_pkg::RATIO_FULL;
        2: ratio = 9'd511;
        default: ratio = 9'($urandom_range(511));
      endcase
      send_command(func, idx, 8'($urandom), 8'($urandom), 8'($urandom), ratio);
    end
  endtask

  // Main sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: one LED, zero store
    send_command(alfs_pkg::FUNC_SET_PIXEL, 10'd1, 8'h12, 8'h34, 8'h56, 9'd0);
    send_command(alfs_pkg::FUNC_PULL, 10'd0, 8'h00, 8'h00, 8'h00, 9'd0);
    send_command(alfs_pkg::FUNC_PULL, 10'd0, 8'h00, 8'h00, 8'h00, 9'd0);

    // Short frame: every pair code, trailer, last flag and wrap
    drain();
    write_config(11'd1, 8'd2);
    send_command(alfs_pkg::FUNC_SET_PIXEL, 10'd0, 8'hE4, 8'h1B, 8'hFF, 9'd0);
    send_command(alfs_pkg::FUNC_SET_PIXEL, 10'd1023, 8'hFF, 8'hFF, 8'hFF, 9'd511);
    repeat (14) send_command(alfs_pkg::FUNC_PULL, 10'd0, 8'h00, 8'h00, 8'h00, 9'd0);
    send_command(alfs_pkg::FUNC_FILL, 10'd0, 8'hFF, 8'h00, 8'h0F, 9'd0);
    // scaled fills: ratio above full scale, zero, exactly full scale
    send_command(alfs_pkg::FUNC_FILL_SCALED, 10'd0, 8'h80, 8'hFF, 8'h01, 9'd511);
    send_command(alfs_pkg::FUNC_PULL, 10'd0, 8'h00, 8'h00, 8'h00, 9'd0);
    send_command(alfs_pkg::FUNC_FILL_SCALED, 10'd0, 8'hFF, 8'hFF, 8'hFF, 9'd0);
    send_command(alfs_pkg::FUNC_FILL_SCALED, 10'd0, 8'hFF, 8'h7F, 8'hC3,
                 alfs_pkg::RATIO_FULL);
    send_command(alfs_pkg::FUNC_PULL, 10'd0, 8'h00, 8'h00, 8'h00, 9'd0);

    // Random phases over several settings and idling modes
    run_phase(11'd5, 8'd0, 150, MODE_NONE);
    run_phase(11'd2, 8'd255, 100, MODE_SENDER);
    run_phase(11'd0, 8'd7, 100, MODE_RECEIVER);
    run_phase(11'd12, 8'd1, 150, MODE_BOTH);
    run_phase(11'd1024, 8'd120, 20, MODE_SENDER);
    run_phase(11'd2047, 8'd0, 15, MODE_RECEIVER);
    run_phase(11'd3, 8'($urandom_range(255)), 150, MODE_NONE);
    run_phase(11'd1, 8'd0, 100, MODE_BOTH);
    run_phase(11'($urandom_range(16, 1)), 8'($urandom_range(255)), 150, MODE_RECEIVER);
    run_phase(11'd1023, 8'd255, 15, MODE_NONE);
    run_phase(11'd7, 8'd40, 100, MODE_SENDER);

    drain();
    repeat (8) @(posedge clk);
    if (mirror.pending.size() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.pending.size()));

    $display("Run covered %0d commands (%0d byte pulls) over %0d register settings.",
             mirror.commands, mirror.pulls, settings_used);
    $display("%0d results checked, %0d mismatches.", mirror.checked, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(50_000_000);
    $display("Timeout waiting on the serializer");
    $display("Some tests failed");
    $finish;
  end

endmodule
